### hdl/cpf_pkg.sv
package cpf_pkg;

    // sizes of the change ring and the staging table
    localparam int RING_DEPTH  = 1024;
    localparam int STAGE_DEPTH = 16;

    localparam int RING_AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int STAGE_AW = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;
    localparam int STAGE_CW = $clog2(STAGE_DEPTH + 1);

    // fixed field widths
    localparam int PLUGIN_W = 8;
    localparam int PARAM_W  = 16;
    localparam int VALUE_W  = 32;
    localparam int MAXOUT_W = 5;
    localparam int QCOUNT_W = 10;
    localparam int STOTAL_W = 5;

    // command codes
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [PLUGIN_W-1:0] plugin_id;
        logic [PARAM_W-1:0]  param_id;
        logic [VALUE_W-1:0]  param_value;
        logic [MAXOUT_W-1:0] max_out;
        logic                keep_staged;
    } t_in;

    typedef struct packed {
        logic                accepted;
        logic                entry_valid;
        logic [PLUGIN_W-1:0] out_plugin;
        logic [PARAM_W-1:0]  out_param;
        logic [VALUE_W-1:0]  out_value;
        logic                last;
        logic [QCOUNT_W-1:0] queue_count;
        logic [STOTAL_W-1:0] staged_total;
    } t_out;

    typedef struct packed {
        logic [PLUGIN_W-1:0] plugin;
        logic [PARAM_W-1:0]  param;
    } t_key;

    typedef struct packed {
        t_key               key;
        logic [VALUE_W-1:0] value;
    } t_ring_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_UPD,
        ST_EMRD,
        ST_EMOUT,
        ST_FINAL
    } t_state;

endpackage

### hdl/cpf_ram.sv
module cpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/coalescing_param_fifo_unit.sv
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+---------------------------
// in       | input     | i_in_valid / o_in_stall   | i_in_data  (cpf_pkg::t_in)
// out      | output    | o_out_valid / i_out_stall | o_out_data (cpf_pkg::t_out)
//
// a push or a no-op drain is taken in idle and gives one result
// a drain leaves idle, then for each change read from the ring does a ring read, a key
// compare and a value write-back, the change left queued by a full table included,
// one more ring read when the ring runs empty, then for each staged entry a value read
// and a transfer, or one closing result when nothing is staged; output stalls hold back each transfer
// the ring and staged values live in synchronous memories with registered reads
// reset clears pointers, counts, index, match vector, limit, output valid and the state machine only; no clearing pass
// a new item enters only in idle, with the output register empty or its result
// leaving that cycle; stall holds the waiting result
module coalescing_param_fifo_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cpf_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cpf_pkg::t_out  o_out_data
);

    // control state
    cpf_pkg::t_state                   r_state, n_state;
    logic [cpf_pkg::RING_AW-1:0]       r_wr_ptr, n_wr_ptr;
    logic [cpf_pkg::RING_AW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [cpf_pkg::RING_AW-1:0]       r_count, n_count;
    logic [cpf_pkg::STAGE_CW-1:0]      r_staged, n_staged;
    logic [cpf_pkg::STAGE_CW-1:0]      r_have, n_have;
    logic [cpf_pkg::STAGE_CW-1:0]      r_max, n_max;
    logic [cpf_pkg::STAGE_AW-1:0]      r_idx, n_idx;
    logic [cpf_pkg::STAGE_DEPTH-1:0]   r_match, n_match;
    logic                              r_out_valid, n_out_valid;
    cpf_pkg::t_out                     r_out, n_out;

    // staged keys in flops so every entry can be compared at once
    cpf_pkg::t_key                     r_keys [cpf_pkg::STAGE_DEPTH];
    logic                              key_we;
    logic [cpf_pkg::STAGE_AW-1:0]      key_widx;
    cpf_pkg::t_key                     key_wdata;

    // ring memory
    logic                              ring_we;
    cpf_pkg::t_ring_entry              ring_wdata;
    cpf_pkg::t_ring_entry              ring_rdata;

    // staged value memory
    logic                              val_we;
    logic [cpf_pkg::STAGE_AW-1:0]      val_waddr;
    logic [cpf_pkg::VALUE_W-1:0]       val_rdata;

    logic                              out_ready;
    logic                              out_load;
    logic                              in_fire;
    logic                              ring_full;
    logic                              hit;
    logic [cpf_pkg::STAGE_AW-1:0]      hit_idx;
    logic [cpf_pkg::RING_AW-1:0]       rd_ptr_next;
    logic [cpf_pkg::RING_AW-1:0]       wr_ptr_next;

    cpf_ram #(
        .WIDTH ($bits(cpf_pkg::t_ring_entry)),
        .DEPTH (cpf_pkg::RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (ring_wdata),
        .i_raddr (r_rd_ptr),
        .o_rdata (ring_rdata)
    );

    cpf_ram #(
        .WIDTH (cpf_pkg::VALUE_W),
        .DEPTH (cpf_pkg::STAGE_DEPTH)
    ) u_stage_val (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (ring_rdata.value),
        .i_raddr (r_idx),
        .o_rdata (val_rdata)
    );

    // output register is free when empty or its result is taken this cycle
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == cpf_pkg::ST_IDLE) && out_ready);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign ring_full  = (r_count == cpf_pkg::RING_AW'(cpf_pkg::RING_DEPTH - 1));

    assign rd_ptr_next = (r_rd_ptr == cpf_pkg::RING_AW'(cpf_pkg::RING_DEPTH - 1)) ?
                         '0 : r_rd_ptr + cpf_pkg::RING_AW'(1);
    assign wr_ptr_next = (r_wr_ptr == cpf_pkg::RING_AW'(cpf_pkg::RING_DEPTH - 1)) ?
                         '0 : r_wr_ptr + cpf_pkg::RING_AW'(1);

    assign ring_wdata.key.plugin = i_in_data.plugin_id;
    assign ring_wdata.key.param  = i_in_data.param_id;
    assign ring_wdata.value      = i_in_data.param_value;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // the registered match vector holds at most one bit, pick it out
    always_comb begin
        hit     = |r_match;
        hit_idx = '0;
        for (int i = cpf_pkg::STAGE_DEPTH - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit_idx = cpf_pkg::STAGE_AW'(i);
            end
        end
    end

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_count     = r_count;
        n_staged    = r_staged;
        n_have      = r_have;
        n_max       = r_max;
        n_idx       = r_idx;
        n_match     = r_match;
        n_out       = r_out;
        out_load    = 1'b0;
        ring_we     = 1'b0;
        val_we      = 1'b0;
        val_waddr   = hit_idx;
        key_we      = 1'b0;
        key_widx    = r_have[cpf_pkg::STAGE_AW-1:0];
        key_wdata   = ring_rdata.key;

        case (r_state)
            cpf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.cmd == cpf_pkg::CMD_PUSH) begin
                        out_load             = 1'b1;
                        n_out                = '0;
                        n_out.last           = 1'b1;
                        n_out.staged_total   = cpf_pkg::STOTAL_W'(r_staged);
                        if (ring_full) begin
                            n_out.queue_count = cpf_pkg::QCOUNT_W'(r_count);
                        end else begin
                            ring_we           = 1'b1;
                            n_wr_ptr          = wr_ptr_next;
                            n_count           = r_count + cpf_pkg::RING_AW'(1);
                            n_out.accepted    = 1'b1;
                            n_out.queue_count = cpf_pkg::QCOUNT_W'(n_count);
                        end
                    end else if (i_in_data.max_out == '0) begin
                        // drain with no usable entries: nothing moves
                        out_load           = 1'b1;
                        n_out              = '0;
                        n_out.last         = 1'b1;
                        n_out.queue_count  = cpf_pkg::QCOUNT_W'(r_count);
                        n_out.staged_total = cpf_pkg::STOTAL_W'(r_staged);
                    end else begin
                        if (int'(i_in_data.max_out) > cpf_pkg::STAGE_DEPTH) begin
                            n_max = cpf_pkg::STAGE_CW'(cpf_pkg::STAGE_DEPTH);
                        end else begin
                            n_max = cpf_pkg::STAGE_CW'(i_in_data.max_out);
                        end
                        n_have  = i_in_data.keep_staged ? r_staged : '0;
                        n_state = cpf_pkg::ST_RD;
                    end
                end
            end

            cpf_pkg::ST_RD: begin
                // ring read address is the read pointer; data follows next cycle
                if (r_count == '0) begin
                    n_staged = r_have;
                    n_idx    = '0;
                    n_state  = (r_have == '0) ? cpf_pkg::ST_FINAL : cpf_pkg::ST_EMRD;
                end else begin
                    n_state = cpf_pkg::ST_CMP;
                end
            end

            cpf_pkg::ST_CMP: begin
                for (int i = 0; i < cpf_pkg::STAGE_DEPTH; i++) begin
                    n_match[i] = (cpf_pkg::STAGE_CW'(i) < r_have) &&
                                 (r_keys[i] == ring_rdata.key);
                end
                n_state = cpf_pkg::ST_UPD;
            end

            cpf_pkg::ST_UPD: begin
                if (hit) begin
                    // coalesce onto the staged entry
                    val_we   = 1'b1;
                    n_rd_ptr = rd_ptr_next;
                    n_count  = r_count - cpf_pkg::RING_AW'(1);
                    n_state  = cpf_pkg::ST_RD;
                end else if (r_have < r_max) begin
                    val_we    = 1'b1;
                    val_waddr = r_have[cpf_pkg::STAGE_AW-1:0];
                    key_we    = 1'b1;
                    n_have    = r_have + cpf_pkg::STAGE_CW'(1);
                    n_rd_ptr  = rd_ptr_next;
                    n_count   = r_count - cpf_pkg::RING_AW'(1);
                    n_state   = cpf_pkg::ST_RD;
                end else begin
                    // no free entry: the change stays queued
                    n_staged = r_have;
                    n_idx    = '0;
                    n_state  = (r_have == '0) ? cpf_pkg::ST_FINAL : cpf_pkg::ST_EMRD;
                end
            end

            cpf_pkg::ST_EMRD: begin
                n_state = cpf_pkg::ST_EMOUT;
            end

            cpf_pkg::ST_EMOUT: begin
                if (out_ready) begin
                    out_load           = 1'b1;
                    n_out.accepted     = 1'b1;
                    n_out.entry_valid  = 1'b1;
                    n_out.out_plugin   = r_keys[r_idx].plugin;
                    n_out.out_param    = r_keys[r_idx].param;
                    n_out.out_value    = val_rdata;
                    n_out.last         = ((cpf_pkg::STAGE_CW'(r_idx) + cpf_pkg::STAGE_CW'(1))
                                          == r_staged);
                    n_out.queue_count  = cpf_pkg::QCOUNT_W'(r_count);
                    n_out.staged_total = cpf_pkg::STOTAL_W'(r_staged);
                    if (n_out.last) begin
                        n_state = cpf_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + cpf_pkg::STAGE_AW'(1);
                        n_state = cpf_pkg::ST_EMRD;
                    end
                end
            end

            cpf_pkg::ST_FINAL: begin
                // drain that ended with nothing staged
                if (out_ready) begin
                    out_load           = 1'b1;
                    n_out              = '0;
                    n_out.accepted     = 1'b1;
                    n_out.last         = 1'b1;
                    n_out.queue_count  = cpf_pkg::QCOUNT_W'(r_count);
                    n_out.staged_total = '0;
                    n_state            = cpf_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = cpf_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cpf_pkg::ST_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_staged    <= '0;
            r_have      <= '0;
            r_max       <= '0;
            r_idx       <= '0;
            r_match     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_count     <= n_count;
            r_staged    <= n_staged;
            r_have      <= n_have;
            r_max       <= n_max;
            r_idx       <= n_idx;
            r_match     <= n_match;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (key_we) begin
            r_keys[key_widx] <= key_wdata;
        end
    end

    // staged keys are unique, so a change matches at most one entry
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpf_pkg::ST_UPD) |-> $onehot0(r_match))
        else $error("change matched more than one staged entry");

    // the staged count never passes the table size
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_staged <= cpf_pkg::STAGE_CW'(cpf_pkg::STAGE_DEPTH))
        else $error("staged count beyond table size");

    // a push into a ring with room grows the queue by one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in_data.cmd == cpf_pkg::CMD_PUSH) && !ring_full)
        |=> (r_count == $past(r_count) + cpf_pkg::RING_AW'(1)))
        else $error("push did not advance queue count");

    // no result is produced while the ring walk is under way
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == cpf_pkg::ST_RD) || (r_state == cpf_pkg::ST_CMP) ||
         (r_state == cpf_pkg::ST_UPD)) |-> !out_load)
        else $error("result transfer during ring walk");

endmodule

### sim/coalescing_param_fifo_unit_tb.sv
`timescale 1ns / 100ps

module coalescing_param_fifo_unit_tb;

    localparam int WATCHDOG_LIMIT   = 20000;   // quiet cycles before giving up
    localparam int END_DRAIN_CYCLES = 64;      // settle time once nothing is expected
    localparam int HOLD_OFF_CYCLES  = 300;     // long receiver hold-off

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           o_in_stall;
    cpf_pkg::t_in   i_in_data   = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    cpf_pkg::t_out  o_out_data;

    coalescing_param_fifo_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // predictor state: pending change ring and staging table
    cpf_pkg::t_ring_entry change_ring [cpf_pkg::RING_DEPTH];
    cpf_pkg::t_ring_entry stage_table [cpf_pkg::STAGE_DEPTH];
    int unsigned ring_wr    = 0;
    int unsigned ring_rd    = 0;
    int unsigned stage_used = 0;

    cpf_pkg::t_out predicted_results [$];

    // idling control
    bit          sender_idle_en = 1'b1;
    bit          recv_idle_en   = 1'b1;
    bit          hold_req       = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned stall_burst    = 0;

    // bookkeeping
    int unsigned err_count      = 0;
    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned drains_sent    = 0;
    int unsigned noop_drains    = 0;
    int unsigned refused_pushes = 0;
    int unsigned coalesced      = 0;
    int unsigned deepest_fill   = 0;

    function automatic logic [cpf_pkg::QCOUNT_W-1:0] pending_changes();
        return cpf_pkg::QCOUNT_W'((ring_wr + cpf_pkg::RING_DEPTH - ring_rd)
                                  % cpf_pkg::RING_DEPTH);
    endfunction

    function automatic cpf_pkg::t_out status_result(input logic acc);
        cpf_pkg::t_out r;
        r              = '0;
        r.accepted     = acc;
        r.last         = 1'b1;
        r.queue_count  = pending_changes();
        r.staged_total = cpf_pkg::STOTAL_W'(stage_used);
        return r;
    endfunction

    // work out every result that one accepted item causes
    task automatic predict_fifo_step(input cpf_pkg::t_in item);
        int unsigned   limit;
        int unsigned   have;
        int unsigned   nxt;
        int unsigned   i;
        bit            hit;
        cpf_pkg::t_out r;
        if (item.cmd == cpf_pkg::CMD_PUSH) begin
            nxt = (ring_wr + 1) % cpf_pkg::RING_DEPTH;
            if (nxt == ring_rd) begin
                refused_pushes++;
                predicted_results.push_back(status_result(1'b0));
            end else begin
                change_ring[ring_wr].key.plugin = item.plugin_id;
                change_ring[ring_wr].key.param  = item.param_id;
                change_ring[ring_wr].value      = item.param_value;
                ring_wr = nxt;
                if (pending_changes() > deepest_fill) deepest_fill = pending_changes();
                predicted_results.push_back(status_result(1'b1));
            end
            return;
        end
        drains_sent++;
        if (item.max_out == '0) begin
            noop_drains++;
            predicted_results.push_back(status_result(1'b0));
            return;
        end
        limit = (item.max_out > cpf_pkg::STAGE_DEPTH) ? cpf_pkg::STAGE_DEPTH : item.max_out;
        have  = item.keep_staged ? stage_used : 0;
        while (ring_rd != ring_wr) begin
            hit = 1'b0;
            for (i = 0; i < have; i++) begin
                if (stage_table[i].key == change_ring[ring_rd].key) begin
                    stage_table[i].value = change_ring[ring_rd].value;
                    hit = 1'b1;
                    coalesced++;
                    break;
                end
            end
            if (!hit) begin
                if (have < limit) begin
                    stage_table[have] = change_ring[ring_rd];
                    have++;
                end else begin
                    break;
                end
            end
            ring_rd = (ring_rd + 1) % cpf_pkg::RING_DEPTH;
        end
        stage_used = have;
        if (have == 0) begin
            predicted_results.push_back(status_result(1'b1));
            return;
        end
        for (i = 0; i < have; i++) begin
            r             = status_result(1'b1);
            r.entry_valid = 1'b1;
            r.out_plugin  = stage_table[i].key.plugin;
            r.out_param   = stage_table[i].key.param;
            r.out_value   = stage_table[i].value;
            r.last        = (i + 1 == have);
            predicted_results.push_back(r);
        end
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input cpf_pkg::t_in item);
        if (sender_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        predict_fifo_step(item);
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (predicted_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic cpf_pkg::t_in push_change(input logic [cpf_pkg::PLUGIN_W-1:0] plug,
                                                 input logic [cpf_pkg::PARAM_W-1:0] par,
                                                 input logic [cpf_pkg::VALUE_W-1:0] val);
        cpf_pkg::t_in r;
        r.cmd          = cpf_pkg::CMD_PUSH;
        r.plugin_id    = plug;
        r.param_id     = par;
        r.param_value  = val;
        r.max_out      = cpf_pkg::MAXOUT_W'($urandom);   // ignored on a push
        r.keep_staged  = 1'($urandom);
        return r;
    endfunction

    function automatic cpf_pkg::t_in drain_cmd(input logic [cpf_pkg::MAXOUT_W-1:0] max_out,
                                               input logic keep);
        cpf_pkg::t_in r;
        r.cmd          = cpf_pkg::CMD_DRAIN;
        r.plugin_id    = cpf_pkg::PLUGIN_W'($urandom);   // ignored on a drain
        r.param_id     = cpf_pkg::PARAM_W'($urandom);
        r.param_value  = $urandom;
        r.max_out      = max_out;
        r.keep_staged  = keep;
        return r;
    endfunction

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req    = 1'b0;
                hold_left   = HOLD_OFF_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else if (stall_burst > 0) begin
                stall_burst--;
                i_out_stall <= 1'b1;
            end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
                stall_burst = $urandom_range(1, 15) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // result checker
    initial begin
        cpf_pkg::t_out want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                results_seen++;
                if (predicted_results.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result %h at %0t", o_out_data, $realtime);
                end else begin
                    want = predicted_results.pop_front();
                    if (o_out_data !== want) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("mismatch at %0t", $realtime);
                            $display({"  expected acc %b ent %b plug %h par %h val %h",
                                      " last %b qc %0d st %0d"},
                                     want.accepted, want.entry_valid, want.out_plugin,
                                     want.out_param, want.out_value, want.last,
                                     want.queue_count, want.staged_total);
                            $display({"  actual   acc %b ent %b plug %h par %h val %h",
                                      " last %b qc %0d st %0d"},
                                     o_out_data.accepted, o_out_data.entry_valid,
                                     o_out_data.out_plugin, o_out_data.out_param,
                                     o_out_data.out_value, o_out_data.last,
                                     o_out_data.queue_count, o_out_data.staged_total);
                        end
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // extremes of every field and each corner of the drain
    task automatic test_directed();
        send_item(drain_cmd(5'd0, 1'b0));                 // no-op drain
        send_item(drain_cmd(5'd4, 1'b0));                 // drain of an empty ring
        send_item(drain_cmd(5'd3, 1'b1));                 // keep with nothing held
        send_item(push_change(8'h00, 16'h0000, 32'h0000_0000));
        send_item(push_change(8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(push_change(8'h00, 16'h0000, 32'h1234_5678));  // coalesces with the first
        send_item(push_change(8'h01, 16'h0000, 32'hDEAD_BEEF));
        send_item(push_change(8'h00, 16'h0001, 32'h8000_0001));
        send_item(drain_cmd(5'd2, 1'b0));                 // table fills, changes stay queued
        send_item(drain_cmd(5'd1, 1'b1));                 // more held than allowed
        send_item(push_change(8'hFF, 16'hFFFF, 32'hA5A5_A5A5));
        send_item(drain_cmd(5'd31, 1'b1));                // saturates to the table depth
        send_item(drain_cmd(5'd16, 1'b0));                // empties the table
        send_item(push_change(8'h80, 16'h8000, 32'h7FFF_FFFF));
        send_item(push_change(8'h7F, 16'h7FFF, 32'h0000_0001));
        send_item(drain_cmd(5'd1, 1'b0));
        send_item(drain_cmd(5'd16, 1'b1));
        send_item(drain_cmd(5'd17, 1'b1));
        send_item(drain_cmd(5'd0, 1'b1));
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int unsigned n_items);
        cpf_pkg::t_in                  it;
        int unsigned                   k;
        logic [cpf_pkg::PLUGIN_W-1:0]  plug;
        logic [cpf_pkg::PARAM_W-1:0]   par;
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 9) < 7) begin
                plug = ($urandom_range(0, 7) == 0) ? cpf_pkg::PLUGIN_W'($urandom)
                                                   : cpf_pkg::PLUGIN_W'($urandom_range(0, 3));
                par  = ($urandom_range(0, 7) == 0) ? cpf_pkg::PARAM_W'($urandom)
                                                   : cpf_pkg::PARAM_W'($urandom_range(0, 5));
                it   = push_change(plug, par, $urandom);
            end else begin
                case ($urandom_range(0, 9))
                    0:       it = drain_cmd(5'd0, 1'($urandom));
                    1:       it = drain_cmd(cpf_pkg::MAXOUT_W'($urandom_range(17, 31)),
                                            1'($urandom));
                    default: it = drain_cmd(cpf_pkg::MAXOUT_W'($urandom_range(1, 16)),
                                            1'($urandom));
                endcase
            end
            send_item(it);
        end
    endtask

    // receiver holds off while the sender keeps offering, then the sender waits it out
    task automatic test_backpressure();
        int unsigned k;
        sender_idle_en = 1'b0;
        hold_req       = 1'b1;
        for (k = 0; k < 40; k++)
            send_item(push_change(cpf_pkg::PLUGIN_W'($urandom_range(0, 2)),
                                  cpf_pkg::PARAM_W'($urandom_range(0, 2)), $urandom));
        send_item(drain_cmd(5'd16, 1'b0));
        wait_results_drained();
        sender_idle_en = 1'b1;
    endtask

    // closing stretch with no idling on either side
    task automatic test_back_to_back(input int unsigned n_items);
        sender_idle_en = 1'b0;
        recv_idle_en   = 1'b0;
        test_random_traffic(n_items);
        wait_results_drained();
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_traffic(230);
        test_backpressure();
        test_back_to_back(40);

        wait_results_drained();
        repeat (END_DRAIN_CYCLES) @(negedge i_clk);
        if (predicted_results.size() != 0) begin
            err_count++;
            $display("%0d expected results never arrived", predicted_results.size());
        end
        $display("run: %0d items in (%0d drains, %0d no-op, %0d refused pushes), %0d results out",
                 items_sent, drains_sent, noop_drains, refused_pushes, results_seen);
        $display("run: %0d coalesced writes, deepest ring fill %0d, %0d errors",
                 coalesced, deepest_fill, err_count);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
hdl/cpf_pkg.sv
hdl/cpf_ram.sv
hdl/coalescing_param_fifo_unit.sv
sim/coalescing_param_fifo_unit_tb.sv
